FILE: hw/rtl/multi_policy_task_scheduler_assert.svh
`ifndef MULTI_POLICY_TASK_SCHEDULER_ASSERT_SVH
`define MULTI_POLICY_TASK_SCHEDULER_ASSERT_SVH
// assertion helpers
`define MPTS_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("%m: label");
`define MPTS_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("%m: label");
`endif

FILE: hw/rtl/mpts_pkg.sv
package mpts_pkg;
  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_TICK  = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;
  localparam logic [2:0] POL_FCFS  = 3'd0;
  localparam logic [2:0] POL_SJF   = 3'd1;
  localparam logic [2:0] POL_SRTF  = 3'd2;
  localparam logic [2:0] POL_PRIO  = 3'd3;
  localparam logic [2:0] POL_PRIOP = 3'd4;
  localparam logic [2:0] POL_RR    = 3'd5;
  localparam logic       CFG_POLICY  = 1'b0;
  localparam logic       CFG_QUANTUM = 1'b1;
  localparam logic [15:0] TIME_MAX = 16'hffff;

  // candidate travelling along the cell chain
  typedef struct packed {
    logic        found;
    logic [5:0]  slot;
    logic [16:0] key;
  } cand_t;

  // per cell control from the top level
  typedef struct packed {
    logic        load;
    logic        clear;
    logic        run;
    logic [5:0]  run_slot;
    logic [15:0] now;
    logic [2:0]  pol;
    logic [5:0]  rr_base;
  } cell_ctl_t;
endpackage

FILE: hw/rtl/mpts_cell.sv
module mpts_cell import mpts_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cell_ctl_t   ctl,
  input  logic [7:0]  ld_prio,
  input  logic [15:0] ld_arrival,
  input  logic [15:0] ld_burst,
  input  cand_t       cand_in,
  output cand_t       cand_out,
  output logic        rdy,
  output logic        busy,
  output logic        was_started,
  output logic [15:0] start_val,
  output logic [15:0] arrival_val,
  output logic [15:0] burst_val,
  output logic [15:0] rem_val
);
  logic        valid_r, started_r;
  logic [7:0]  prio_r;
  logic [15:0] arr_r, burst_r, rem_r, st_r;
  logic [16:0] key;
  logic [5:0]  me;
  cand_t       cand_r, cand_nxt;

  assign me = 6'(IDX);
  assign rdy  = valid_r && rem_r != 16'd0 && arr_r <= ctl.now;
  assign busy = valid_r && rem_r != 16'd0;
  assign was_started = started_r;
  assign start_val = st_r;
  assign arrival_val = arr_r;
  assign burst_val = burst_r;
  assign rem_val = rem_r;
  assign cand_out = cand_r;

  always_comb begin
    case (ctl.pol)
      POL_SJF:             key = {1'b0, burst_r};
      POL_SRTF:            key = {1'b0, rem_r};
      POL_PRIO, POL_PRIOP: key = {9'd0, prio_r};
      // round robin: distance from base for slots at or above it; slots below base rank after them
      POL_RR:              key = (me >= ctl.rr_base) ? {11'd0, me - ctl.rr_base}
                                                     : {11'd1, me};
      default:             key = {1'b0, arr_r};
    endcase
    cand_nxt = cand_in;
    if (rdy && (!cand_in.found || key < cand_in.key)) begin
      cand_nxt.found = 1'b1;
      cand_nxt.slot  = me;
      cand_nxt.key   = key;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_r <= '0;
    end else begin
      cand_r <= cand_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      valid_r   <= 1'b0;
      started_r <= 1'b0;
    end else if (ctl.load) begin
      valid_r   <= 1'b1;
      started_r <= 1'b0;
      prio_r    <= ld_prio;
      arr_r     <= ld_arrival;
      burst_r   <= ld_burst;
      rem_r     <= ld_burst;
    end else if (ctl.run && ctl.run_slot == me) begin
      rem_r <= rem_r - 16'd1;
      if (!started_r) begin
        started_r <= 1'b1;
        st_r      <= ctl.now;
      end
    end
  end
endmodule

FILE: hw/rtl/multi_policy_task_scheduler.sv
// a tick word runs the registered select pass down the cell chain in state S_SEL, then
// S_UPD registers the result word; input is taken only in the idle state and not while
// a result waits for the output handshake, so a waiting result holds off input
// loads, clears and config writes give no result
// reset: synchronous active low rst_n; empties the table, zeroes time,
// policy returns to fcfs and quantum to 3
`include "multi_policy_task_scheduler_assert.svh"
module multi_policy_task_scheduler import mpts_pkg::*; #(
  parameter int TASKS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // action[1:0], slot[5:2], task_priority[13:6], arrival[29:14], burst[45:30], pad
  input  logic [47:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // now_tick[15:0], ran[16], ran_slot[20:17], finished[21], first_start[37:22],
  // waiting[53:38], turnaround[69:54], all_done[70], pad
  output logic [71:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);
  localparam int SW = $clog2(TASKS);
  localparam int CW = $clog2(TASKS + 1);

  typedef enum logic [1:0] {S_IDLE, S_SEL, S_UPD} state_t;
  state_t state_r;

  logic [2:0]  policy_r;
  logic [7:0]  quantum_r;
  logic [15:0] clock_r;
  logic        hold_v_r;
  logic [SW-1:0] hold_s_r, rr_r;
  logic [7:0]  qused_r;
  logic [SW-1:0] sel_r;
  logic        sel_v_r;
  logic [CW-1:0] cnt_r;
  logic [71:0] out_r;
  logic        out_v_r;

  logic [1:0]  act;
  logic [3:0]  slot_in;
  logic        accept;
  cand_t       chain [TASKS+1];
  cell_ctl_t   ctl;
  logic [TASKS-1:0] rdy, busy, strt;
  logic [15:0] stv [TASKS], arv [TASKS], buv [TASKS], rmv [TASKS];
  logic [TASKS-1:0] ld_hit;
  logic [2:0]  pol;
  logic [7:0]  q_eff;
  logic        keep;
  logic [SW-1:0] pick;
  logic        pick_v;

  assign act     = in_tdata[1:0];
  assign slot_in = in_tdata[5:2];
  assign in_tready = state_r == S_IDLE && !out_v_r;
  assign accept  = in_tvalid && in_tready;
  assign cfg_ready = state_r == S_IDLE;
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_r;
  assign pol   = (policy_r > POL_RR) ? POL_FCFS : policy_r;
  assign q_eff = (quantum_r == 8'd0) ? 8'd1 : quantum_r;

  assign ctl.load     = 1'b0;
  assign ctl.clear    = accept && act == ACT_CLEAR;
  assign ctl.run      = state_r == S_UPD && sel_v_r;
  assign ctl.run_slot = 6'(sel_r);
  assign ctl.now      = clock_r;
  assign ctl.pol      = pol;
  assign ctl.rr_base  = 6'(rr_r);

  assign chain[0] = '0;
  genvar g;
  generate
    for (g = 0; g < TASKS; g++) begin : g_cell
      cell_ctl_t c;
      always_comb begin
        c = ctl;
        c.load = ld_hit[g];
      end
      assign ld_hit[g] = accept && act == ACT_LOAD && {2'b0, slot_in} == 6'(g);
      mpts_cell #(.IDX(g)) u_cell (
        .clk(clk), .rst_n(rst_n), .ctl(c),
        .ld_prio(in_tdata[13:6]), .ld_arrival(in_tdata[29:14]),
        .ld_burst(in_tdata[45:30]),
        .cand_in(chain[g]), .cand_out(chain[g+1]),
        .rdy(rdy[g]), .busy(busy[g]), .was_started(strt[g]),
        .start_val(stv[g]), .arrival_val(arv[g]), .burst_val(buv[g]),
        .rem_val(rmv[g])
      );
    end
  endgenerate

  always_comb begin
    keep = 1'b0;
    if (hold_v_r && rdy[hold_s_r]) begin
      if (pol == POL_RR) keep = qused_r < q_eff;
      else keep = pol == POL_FCFS || pol == POL_SJF || pol == POL_PRIO;
    end
    pick_v = keep || chain[TASKS].found;
    pick   = keep ? hold_s_r : chain[TASKS].slot[SW-1:0];
  end

  logic [15:0] fin, tat, wt, rem1;
  logic        fin_now, done_all;
  logic [71:0] out_nxt;
  always_comb begin
    fin  = (clock_r < TIME_MAX) ? clock_r + 16'd1 : TIME_MAX;
    tat  = fin - arv[sel_r];
    wt   = (tat >= buv[sel_r]) ? tat - buv[sel_r] : 16'd0;
    rem1 = rmv[sel_r] - 16'd1;
    fin_now = sel_v_r && rem1 == 16'd0;
    done_all = 1'b1;
    for (int k = 0; k < TASKS; k++)
      if (busy[k] && !(sel_v_r && SW'(k) == sel_r && fin_now)) done_all = 1'b0;
    out_nxt = '0;
    out_nxt[15:0] = clock_r;
    out_nxt[70] = done_all;
    if (sel_v_r) begin
      out_nxt[16] = 1'b1;
      out_nxt[20:17] = 4'(sel_r);
      if (fin_now) begin
        out_nxt[21] = 1'b1;
        out_nxt[37:22] = strt[sel_r] ? stv[sel_r] : clock_r;
        out_nxt[53:38] = wt;
        out_nxt[69:54] = tat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      policy_r <= POL_FCFS;
      quantum_r <= 8'd3;
      clock_r <= '0; hold_v_r <= 1'b0; hold_s_r <= '0; qused_r <= '0; rr_r <= '0;
      out_v_r <= 1'b0; sel_v_r <= 1'b0; sel_r <= '0; cnt_r <= '0;
    end else begin
      if (out_v_r && out_tready) out_v_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_POLICY) policy_r <= cfg_data[2:0];
        else quantum_r <= cfg_data;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (act == ACT_TICK) begin
              state_r <= S_SEL;
              cnt_r <= '0;
            end else if (act == ACT_CLEAR) begin
              clock_r <= '0; hold_v_r <= 1'b0; hold_s_r <= '0;
              qused_r <= '0; rr_r <= '0;
            end else if (act == ACT_LOAD && 32'(slot_in) < TASKS && hold_v_r &&
                         32'(hold_s_r) == 32'(slot_in)) begin
              hold_v_r <= 1'b0; qused_r <= '0;
            end
          end
        end
        S_SEL: begin
          if (32'(cnt_r) == TASKS) begin
            sel_r <= pick; sel_v_r <= pick_v;
            state_r <= S_UPD;
          end else begin
            cnt_r <= cnt_r + CW'(1);
          end
        end
        S_UPD: begin
          state_r <= S_IDLE;
          out_v_r <= 1'b1;
          out_r <= out_nxt;
          if (sel_v_r) begin
            rr_r <= (32'(sel_r) == TASKS-1) ? '0 : sel_r + SW'(1);
            if (fin_now) begin
              hold_v_r <= 1'b0; qused_r <= '0;
            end else begin
              hold_v_r <= 1'b1; hold_s_r <= sel_r;
              if (hold_v_r && hold_s_r == sel_r)
                qused_r <= (qused_r < 8'd255) ? qused_r + 8'd1 : qused_r;
              else qused_r <= 8'd1;
            end
          end
          if (clock_r < TIME_MAX) clock_r <= clock_r + 16'd1;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `MPTS_ASSERT_IMP(a_no_accept_busy, clk, rst_n, state_r != S_IDLE, !in_tready)
  `MPTS_ASSERT_NXT(a_upd_gives_word, clk, rst_n, state_r == S_UPD, out_v_r)
  `MPTS_ASSERT_IMP(a_sel_ready, clk, rst_n, state_r == S_UPD && sel_v_r, rdy[sel_r])
endmodule

FILE: bench/tb_top.sv
module tb_top;
  import mpts_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT = 16;

  typedef struct packed {
    logic [15:0] now_tick;
    logic        ran;
    logic [3:0]  ran_slot;
    logic        finished;
    logic [15:0] first_start;
    logic [15:0] waiting;
    logic [15:0] turnaround;
    logic        all_done;
  } tick_rpt_t;

  typedef struct {
    logic [1:0]  act;
    logic [3:0]  slot;
    logic [7:0]  prio;
    logic [15:0] arr;
    logic [15:0] burst;
    bit          has_exp;
    logic [15:0] exp_now;
    logic        exp_ran;
    logic        exp_done;
  } dir_row_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [47:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [71:0] out_tdata;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic cfg_index = 0;
  logic [7:0] cfg_data = '0;

  always #5 clk = ~clk;

  multi_policy_task_scheduler u_dut (.*);

  // scheduler shadow state
  logic [2:0]  sh_policy;
  logic [7:0]  sh_quantum;
  bit          sh_valid [NSLOT];
  logic [7:0]  sh_prio [NSLOT];
  logic [15:0] sh_arr [NSLOT];
  logic [15:0] sh_burst [NSLOT];
  logic [15:0] sh_rem [NSLOT];
  bit          sh_started [NSLOT];
  logic [15:0] sh_start [NSLOT];
  logic [15:0] sh_clock;
  bit          sh_hold_v;
  logic [3:0]  sh_hold;
  logic [7:0]  sh_qused;
  logic [3:0]  sh_rr_next;

  tick_rpt_t pending_rpts[$];
  int errors = 0, mismatches = 0, ticks_seen = 0, finishes_seen = 0;
  bit stall_long = 0;

  function automatic void clear_sched();
    for (int i = 0; i < NSLOT; i++) begin
      sh_valid[i] = 0; sh_prio[i] = 0; sh_arr[i] = 0; sh_burst[i] = 0;
      sh_rem[i] = 0; sh_started[i] = 0; sh_start[i] = 0;
    end
    sh_clock = 0; sh_hold_v = 0; sh_hold = 0; sh_qused = 0; sh_rr_next = 0;
  endfunction

  function automatic bit is_ready(int s);
    return sh_valid[s] && sh_rem[s] != 0 && sh_arr[s] <= sh_clock;
  endfunction

  function automatic int key_of(int s, logic [2:0] pol);
    case (pol)
      POL_SJF: return sh_burst[s];
      POL_SRTF: return sh_rem[s];
      POL_PRIO, POL_PRIOP: return sh_prio[s];
      default: return sh_arr[s];
    endcase
  endfunction

  function automatic int pick_slot();
    logic [2:0] pol;
    int best, c, q;
    pol = sh_policy > POL_RR ? POL_FCFS : sh_policy;
    best = NSLOT;
    if (pol == POL_RR) begin
      q = sh_quantum == 0 ? 1 : sh_quantum;
      if (sh_hold_v && is_ready(sh_hold) && sh_qused < q) return sh_hold;
      for (int s = 0; s < NSLOT; s++) begin
        c = (sh_rr_next + s) % NSLOT;
        if (is_ready(c)) return c;
      end
      return NSLOT;
    end
    if ((pol == POL_FCFS || pol == POL_SJF || pol == POL_PRIO) && sh_hold_v &&
        is_ready(sh_hold)) return sh_hold;
    for (int s = 0; s < NSLOT; s++)
      if (is_ready(s) && (best == NSLOT || key_of(s, pol) < key_of(best, pol))) best = s;
    return best;
  endfunction

  function automatic void schedule_word(logic [47:0] w);
    logic [1:0] act;
    int s;
    int fin, tat;
    tick_rpt_t r;
    act = w[1:0];
    if (act == ACT_LOAD) begin
      s = w[5:2];
      sh_valid[s] = 1; sh_prio[s] = w[13:6]; sh_arr[s] = w[29:14];
      sh_burst[s] = w[45:30]; sh_rem[s] = w[45:30]; sh_started[s] = 0; sh_start[s] = 0;
      if (sh_hold_v && sh_hold == s) begin
        sh_hold_v = 0; sh_qused = 0;
      end
      return;
    end
    if (act == ACT_CLEAR) begin
      clear_sched();
      return;
    end
    if (act != ACT_TICK) return;
    r = '0;
    r.now_tick = sh_clock;
    s = pick_slot();
    if (s < NSLOT) begin
      if (!(sh_hold_v && sh_hold == s)) sh_qused = 0;
      sh_hold_v = 1; sh_hold = 4'(s);
      if (sh_qused < 255) sh_qused++;
      sh_rr_next = 4'((s + 1) % NSLOT);
      if (!sh_started[s]) begin
        sh_started[s] = 1; sh_start[s] = sh_clock;
      end
      sh_rem[s]--;
      r.ran = 1; r.ran_slot = 4'(s);
      if (sh_rem[s] == 0) begin
        fin = sh_clock < TIME_MAX ? sh_clock + 1 : TIME_MAX;
        tat = fin - sh_arr[s];
        r.finished = 1;
        r.first_start = sh_start[s];
        r.waiting = 16'(tat >= sh_burst[s] ? tat - sh_burst[s] : 0);
        r.turnaround = 16'(tat);
        sh_hold_v = 0; sh_qused = 0;
      end
    end
    if (sh_clock < TIME_MAX) sh_clock++;
    r.all_done = 1;
    for (int k = 0; k < NSLOT; k++)
      if (sh_valid[k] && sh_rem[k] != 0) r.all_done = 0;
    pending_rpts = {pending_rpts, r};
  endfunction

  function automatic logic [47:0] pack_word(logic [1:0] a, logic [3:0] s, logic [7:0] p,
                                            logic [15:0] ar, logic [15:0] b);
    return {2'b00, b, ar, p, s, a};
  endfunction

  function automatic tick_rpt_t unpack_rpt(logic [71:0] d);
    tick_rpt_t r;
    r.now_tick = d[15:0]; r.ran = d[16]; r.ran_slot = d[20:17]; r.finished = d[21];
    r.first_start = d[37:22]; r.waiting = d[53:38]; r.turnaround = d[69:54];
    r.all_done = d[70];
    return r;
  endfunction

  // valid stays up after a word so the next one can follow at once
  task automatic send_word(logic [47:0] w, int gap);
    if (gap > 0) begin
      in_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= w;
    do @(posedge clk); while (!in_tready);
    schedule_word(w);
  endtask

  task automatic send_rand_gap(logic [47:0] w);
    send_word(w, ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16));
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (pending_rpts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [7:0] val);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_POLICY) sh_policy = val[2:0];
    else sh_quantum = val;
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  // receiver with random stalls
  initial begin
    int wait_n;
    forever begin
      @(posedge clk);
      if (stall_long) begin
        out_tready <= 0;
        wait (!stall_long);
      end else begin
        wait_n = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 16);
        if (wait_n > 0) begin
          out_tready <= 0;
          repeat (wait_n) @(posedge clk);
        end
        out_tready <= 1;
        do @(posedge clk); while (!(out_tvalid && out_tready) && !stall_long);
        if (!stall_long) out_tready <= 0;
      end
    end
  end

  always @(posedge clk) begin
    tick_rpt_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = unpack_rpt(out_tdata);
      ticks_seen++;
      if (got.finished) finishes_seen++;
      if (pending_rpts.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word %h", out_tdata);
      end else begin
        want = pending_rpts.pop_front();
        if (got !== want) begin
          errors++;
          mismatches++;
          if (mismatches <= 10)
            $display("tick word differs: exp %p got %p", want, got);
        end
      end
    end
  end

  initial begin
    dir_row_t dir_rows[$];
    dir_row_t row;
    tick_rpt_t r;
    int kind, s;
    logic [15:0] b;
    sh_policy = POL_FCFS;
    sh_quantum = 3;
    clear_sched();
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed rows: act, slot, prio, arrival, burst, typed check
    dir_rows = '{
      '{ACT_TICK, 0, 0, 0, 0, 1, 16'd0, 0, 0},
      '{2'd3, 15, 255, 16'hffff, 16'hffff, 0, 0, 0, 0},
      '{ACT_LOAD, 0, 255, 0, 1, 0, 0, 0, 0},
      '{ACT_LOAD, 15, 0, 0, 16'hffff, 0, 0, 0, 0},
      '{ACT_LOAD, 3, 7, 0, 0, 0, 0, 0, 0},
      '{ACT_LOAD, 4, 1, 16'hffff, 2, 0, 0, 0, 0},
      '{ACT_TICK, 0, 0, 0, 0, 1, 16'd1, 1, 0},
      '{ACT_TICK, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ACT_TICK, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ACT_LOAD, 15, 2, 1, 2, 0, 0, 0, 0},
      '{ACT_TICK, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ACT_TICK, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ACT_TICK, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ACT_TICK, 0, 0, 0, 0, 1, 16'd0, 0, 1},
      '{ACT_LOAD, 9, 3, 2, 3, 0, 0, 0, 0},
      '{ACT_TICK, 0, 0, 0, 0, 1, 16'd1, 0, 0},
      '{ACT_TICK, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ACT_TICK, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ACT_TICK, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ACT_TICK, 0, 0, 0, 0, 0, 0, 0, 0}
    };
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      send_word(pack_word(row.act, row.slot, row.prio, row.arr, row.burst),
                $urandom_range(0, 4));
      if (row.has_exp) begin
        r = pending_rpts[$];
        if (r.now_tick !== row.exp_now || r.ran !== row.exp_ran ||
            (row.exp_done && r.all_done !== 1'b1)) begin
          errors++;
          $display("directed row %0d: predictor disagrees with table", i);
        end
      end
    end
    drain();

    // random phases over policies and quanta, long stall in one phase
    for (int ph = 0; ph < 10; ph++) begin
      write_reg(CFG_POLICY, 8'(ph < 8 ? ph : $urandom_range(0, 7)));
      write_reg(CFG_QUANTUM, ph == 5 ? 8'd0 : ph == 6 ? 8'd255 : ph == 7 ? 8'd1 :
                8'($urandom_range(0, 255)));
      send_word(pack_word(ACT_CLEAR, 0, 0, 0, 0), 0);
      if (ph == 3) begin
        fork
          begin
            stall_long = 1;
            repeat (300) @(posedge clk);
            stall_long = 0;
          end
        join_none
      end
      for (int it = 0; it < 60; it++) begin
        kind = $urandom_range(0, 99);
        s = $urandom_range(0, 15);
        b = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
        if (kind < 25)
          send_rand_gap(pack_word(ACT_LOAD, 4'(s), 8'($urandom),
                                  16'($urandom_range(0, 40)), b));
        else if (kind < 28)
          send_rand_gap(pack_word(ACT_LOAD, 4'(s), 8'($urandom), 16'($urandom),
                                  16'($urandom)));
        else if (kind < 95)
          send_rand_gap(pack_word(ACT_TICK, 4'($urandom), 8'($urandom), 16'($urandom),
                                  16'($urandom)));
        else if (kind < 97)
          send_rand_gap(pack_word(ACT_CLEAR, 4'($urandom), 8'($urandom), 16'($urandom),
                                  16'($urandom)));
        else
          send_rand_gap(pack_word(2'd3, 4'($urandom), 8'($urandom), 16'($urandom),
                                  16'($urandom)));
        if (it == 30) begin
          in_tvalid <= 0;
          @(posedge clk);
          while (pending_rpts.size() != 0) @(posedge clk);
        end
      end
      drain();
    end
    write_reg(CFG_POLICY, POL_FCFS);
    write_reg(CFG_QUANTUM, 8'd3);
    drain();

    $display("ran %0d tick words, %0d task finishes, all policies and quantum extremes",
             ticks_seen, finishes_seen);
    if (errors == 0 && pending_rpts.size() == 0) begin
      $display("multi_policy_task_scheduler: match");
    end else begin
      $display("multi_policy_task_scheduler: mismatch");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("multi_policy_task_scheduler: mismatch");
    $finish;
  end
endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/mpts_pkg.sv
hw/rtl/mpts_cell.sv
hw/rtl/multi_policy_task_scheduler.sv
bench/tb_top.sv
